### design/hdlc_frame_receiver_crc16_assert.svh
// assertion macros for the hdlc frame receiver
// no dependencies; included by the top level
`ifndef HDLC_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define HDLC_FRAME_RECEIVER_CRC16_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HDLCRX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HDLCRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/hdlcrx_pkg.sv
// types, constants and the fcs-16 byte step for the hdlc frame receiver
// no dependencies
package hdlcrx_pkg;

    localparam int BUFFER_SIZE = 128;
    localparam int FILL_W      = $clog2(BUFFER_SIZE + 1);

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] FCS_INIT  = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD  = 16'hF0B8;
    localparam logic [15:0] FCS_POLY  = 16'h8408;

    localparam logic [FILL_W-1:0] FILL_MAX     = FILL_W'(BUFFER_SIZE);
    localparam logic [FILL_W-1:0] FILL_MIN_OK  = FILL_W'(3);
    localparam logic [FILL_W-1:0] FILL_FCS_LEN = FILL_W'(2);

    typedef enum logic [1:0] {
        EV_DATA     = 2'd0,
        EV_GOOD     = 2'd1,
        EV_CRC_ERR  = 2'd2,
        EV_OVERFLOW = 2'd3
    } t_event;

    typedef enum logic [0:0] {
        CFG_COMMAND_ID     = 1'b0,
        CFG_COMMAND_ENABLE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] command_id;
        logic       command_enable;
    } t_cfg;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] command_byte;
        logic       command_match;
        logic [7:0] frame_length;
        logic [6:0] byte_index;
        logic [7:0] data_byte;
    } t_result;

    function automatic logic [15:0] fcs_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ FCS_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

### design/hdlcrx_core.sv
// frame state, unescaping, fcs check and result formation for one byte
// depends on hdlcrx_pkg
module hdlcrx_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat,
    input  logic [7:0]         i_rx_byte,
    input  hdlcrx_pkg::t_cfg   i_cfg,
    output logic               o_res_valid,
    output hdlcrx_pkg::t_result o_res
);
    import hdlcrx_pkg::*;

    logic              r_receiving, n_receiving;
    logic              r_esc, n_esc;
    logic [7:0]        r_prev, n_prev;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_first, n_first;

    always_comb begin
        logic              is_flag;
        logic              is_esc;
        logic              start;
        logic              cur_esc;
        logic [FILL_W-1:0] cur_fill;
        logic [15:0]       cur_crc;
        logic [7:0]        dat;

        n_receiving = r_receiving;
        n_esc       = r_esc;
        n_prev      = r_prev;
        n_fill      = r_fill;
        n_crc       = r_crc;
        n_first     = r_first;
        o_res_valid = 1'b0;
        o_res       = '0;

        is_flag  = (i_rx_byte == FLAG_BYTE);
        is_esc   = (i_rx_byte == ESC_BYTE);
        start    = !r_receiving && (r_prev == FLAG_BYTE) && !is_flag;
        cur_esc  = start ? 1'b0 : r_esc;
        cur_fill = start ? '0 : r_fill;
        cur_crc  = start ? FCS_INIT : r_crc;
        dat      = cur_esc ? (i_rx_byte ^ ESC_XOR) : i_rx_byte;

        if (i_beat) begin
            n_prev = i_rx_byte;
            if (start || (r_receiving && !is_flag)) begin
                n_receiving = 1'b1;
                n_esc       = cur_esc;
                n_fill      = cur_fill;
                n_crc       = cur_crc;
                if (is_esc) begin
                    n_esc = 1'b1;
                end else begin
                    n_esc = 1'b0;
                    if (cur_fill == '0) begin
                        n_first = dat;
                    end
                    o_res_valid        = 1'b1;
                    o_res.event_res    = EV_DATA;
                    o_res.data_byte    = dat;
                    o_res.byte_index   = 7'(cur_fill);
                    if (cur_fill < FILL_MAX) begin
                        n_fill = cur_fill + FILL_W'(1);
                    end
                    n_crc = fcs_step(cur_crc, dat);
                end
                // overflow check does not apply to the opening byte
                if (!start && (n_fill >= FILL_MAX)) begin
                    o_res_valid     = 1'b1;
                    o_res           = '0;
                    o_res.event_res = EV_OVERFLOW;
                    n_fill          = '0;
                    n_receiving     = 1'b0;
                end
            end else if (r_receiving && is_flag) begin
                n_receiving = 1'b0;
                n_fill      = '0;
                o_res_valid = 1'b1;
                if ((r_crc == FCS_GOOD) && (r_fill >= FILL_MIN_OK)) begin
                    o_res.event_res     = EV_GOOD;
                    o_res.frame_length  = 8'(r_fill - FILL_FCS_LEN);
                    o_res.command_match = i_cfg.command_enable &&
                                          (r_first == i_cfg.command_id);
                    o_res.command_byte  = r_first;
                end else begin
                    o_res.event_res = EV_CRC_ERR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_esc       <= 1'b0;
            r_prev      <= '0;
            r_fill      <= '0;
            r_crc       <= FCS_INIT;
            r_first     <= '0;
        end else begin
            r_receiving <= n_receiving;
            r_esc       <= n_esc;
            r_prev      <= n_prev;
            r_fill      <= n_fill;
            r_crc       <= n_crc;
            r_first     <= n_first;
        end
    end

endmodule

### design/hdlc_frame_receiver_crc16.sv
// channel   | dir | tdata (low bit up)                              | tuser
// s_axis    | in  | rx_byte[7:0]                                    | -
// m_axis    | out | data_byte, byte_index, frame_length,            | event_res[1:0]
//           |     | command_match, command_byte (32 bits)           |
// cfg       | in  | i_cfg_we, i_cfg_index (0 command_id, 1 enable), i_cfg_data[7:0]
//
// one byte per cycle while the output register can take a result; a byte that makes
// a result has it in the output register in the cycle after it is accepted
// synchronous active-low reset returns to idle with fcs 0xffff and config zero
// a stalled output blocks input only while the output register stays full
// depends on hdlcrx_pkg, hdlcrx_core and hdlc_frame_receiver_crc16_assert.svh
module hdlc_frame_receiver_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_byte[7:0], byte_index[14:8], frame_length[22:15],
    // command_match[23], command_byte[31:24]
    output logic [31:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // event_res[1:0]
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import hdlcrx_pkg::*;

    `include "hdlc_frame_receiver_crc16_assert.svh"

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out_res;
    logic    beat;
    logic    res_valid;
    t_result res;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign beat          = s_axis_tvalid && s_axis_tready;

    hdlcrx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_rx_byte   (s_axis_tdata),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_COMMAND_ID:     r_cfg.command_id     <= i_cfg_data;
                CFG_COMMAND_ENABLE: r_cfg.command_enable <= i_cfg_data[0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= beat && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && beat && res_valid) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_res.event_res;
    assign m_axis_tdata  = {r_out_res.command_byte, r_out_res.command_match,
                            r_out_res.frame_length, r_out_res.byte_index,
                            r_out_res.data_byte};

    `HDLCRX_ASSERT_NOW(a_data_no_frame_fields, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser == EV_DATA), m_axis_tdata[31:15] == '0,
        "data beat carries frame-end fields")
    `HDLCRX_ASSERT_NOW(a_good_no_data_fields, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser == EV_GOOD), m_axis_tdata[14:0] == '0,
        "good frame beat carries data fields")
    `HDLCRX_ASSERT_NOW(a_error_all_zero, i_clk, i_rst_n,
        m_axis_tvalid && ((m_axis_tuser == EV_CRC_ERR) || (m_axis_tuser == EV_OVERFLOW)),
        m_axis_tdata == '0, "error beat carries nonzero payload")
    `HDLCRX_ASSERT_NEXT(a_result_registered, i_clk, i_rst_n,
        beat && res_valid, m_axis_tvalid, "result of an accepted byte was dropped")

endmodule

### test/tb.sv
// testbench for hdlc_frame_receiver_crc16: byte stream in, frame events out
// predicts deframing, fcs-16 check, overflow and command match for each accepted beat
// depends on hdlcrx_pkg and the hdlc_frame_receiver_crc16 design
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hdlcrx_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = CFG_COMMAND_ID;
    logic [7:0]  i_cfg_data = 8'h00;

    hdlc_frame_receiver_crc16 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    logic [7:0] pending_bytes[$];
    t_result    expected_results[$];
    logic [7:0] payload[$];
    logic [7:0] last_sent = 8'h00;
    int         queued;
    int         send_idle = 0;
    int         recv_stall = 0;
    int         error_count = 0;

    // receiver state as predicted
    logic [7:0]  cmd_id = 8'h00;
    logic        cmd_enable = 1'b0;
    logic        in_frame = 1'b0;
    logic        esc_pending = 1'b0;
    logic [7:0]  last_rx = 8'h00;
    int          fill = 0;
    logic [15:0] frame_fcs = FCS_INIT;
    logic [7:0]  first_byte = 8'h00;

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("ev %0d data %02h idx %0d len %0d match %0d cmd %02h",
            r.event_res, r.data_byte, r.byte_index, r.frame_length,
            r.command_match, r.command_byte);
    endfunction

    function automatic logic [15:0] fcs16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
                c = (c >> 1) ^ FCS_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic bit take_byte(input logic [7:0] raw, output t_result r);
        logic [7:0] b;
        r = '0;
        if (raw == ESC_BYTE) begin
            esc_pending = 1'b1;
            return 1'b0;
        end
        b = esc_pending ? (raw ^ ESC_XOR) : raw;
        esc_pending = 1'b0;
        if (fill == 0) first_byte = b;
        r.event_res = EV_DATA;
        r.data_byte = b;
        r.byte_index = 7'(fill);
        if (fill < BUFFER_SIZE) fill++;
        frame_fcs = fcs16_byte(frame_fcs, b);
        return 1'b1;
    endfunction

    function automatic void predict_beat(input logic [7:0] raw);
        t_result r;
        bit      emit;
        r = '0;
        emit = 1'b0;
        if (!in_frame && last_rx == FLAG_BYTE && raw != FLAG_BYTE) begin
            in_frame = 1'b1;
            esc_pending = 1'b0;
            fill = 0;
            frame_fcs = FCS_INIT;
            emit = take_byte(raw, r);
        end else if (in_frame && raw != FLAG_BYTE) begin
            emit = take_byte(raw, r);
            if (fill >= BUFFER_SIZE) begin
                r = '0;
                r.event_res = EV_OVERFLOW;
                emit = 1'b1;
                fill = 0;
                in_frame = 1'b0;
            end
        end else if (in_frame) begin
            in_frame = 1'b0;
            emit = 1'b1;
            if (frame_fcs == FCS_GOOD && fill >= 3) begin
                r.event_res = EV_GOOD;
                r.frame_length = 8'(fill - 2);
                r.command_match = cmd_enable && (first_byte == cmd_id);
                r.command_byte = first_byte;
            end else begin
                r.event_res = EV_CRC_ERR;
            end
            fill = 0;
        end
        last_rx = raw;
        if (emit) expected_results.push_back(r);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_beat(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_bytes.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
            if (m_axis_tvalid && m_axis_tready) begin
                seen.event_res = t_event'(m_axis_tuser);
                seen.data_byte = m_axis_tdata[7:0];
                seen.byte_index = m_axis_tdata[14:8];
                seen.frame_length = m_axis_tdata[22:15];
                seen.command_match = m_axis_tdata[23];
                seen.command_byte = m_axis_tdata[31:24];
                if (expected_results.size() == 0) begin
                    note_error($sformatf("unexpected beat: event %0d data %02h",
                        m_axis_tuser, m_axis_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (seen.event_res !== want.event_res || seen.data_byte !== want.data_byte
                        || seen.byte_index !== want.byte_index
                        || seen.frame_length !== want.frame_length
                        || seen.command_match !== want.command_match
                        || seen.command_byte !== want.command_byte) begin
                        note_error($sformatf("mismatch: exp %s, got %s",
                            fmt_result(want), fmt_result(seen)));
                    end
                end
            end
        end
    end

    task automatic send_raw(input logic [7:0] b);
        pending_bytes.push_back(b);
        last_sent = b;
        queued++;
    endtask

    // frames the payload queue; an unclosed frame gets no fcs and no closing flag
    task automatic send_frame(input bit corrupt, input bit closed);
        logic [15:0] crc;
        logic [7:0]  body[$];
        logic [7:0]  flip;
        crc = FCS_INIT;
        foreach (payload[i]) crc = fcs16_byte(crc, payload[i]);
        crc = ~crc;
        flip = corrupt ? 8'(1 << $urandom_range(7)) : 8'h00;
        body = payload;
        if (closed) begin
            body.push_back(crc[7:0] ^ flip);
            body.push_back(crc[15:8]);
        end
        if (last_sent != FLAG_BYTE || $urandom_range(3) == 0) send_raw(FLAG_BYTE);
        foreach (body[i]) begin
            if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE
                || ($urandom_range(15) == 0 && (body[i] ^ ESC_XOR) != FLAG_BYTE
                    && (body[i] ^ ESC_XOR) != ESC_BYTE)) begin
                send_raw(ESC_BYTE);
                send_raw(body[i] ^ ESC_XOR);
            end else begin
                send_raw(body[i]);
            end
        end
        if (closed) send_raw(FLAG_BYTE);
    endtask

    task automatic fill_payload(input int len);
        payload.delete();
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(7) == 0) begin
                payload.push_back($urandom_range(1) ? FLAG_BYTE : ESC_BYTE);
            end else begin
                payload.push_back(8'($urandom_range(255)));
            end
        end
        if (len > 0 && $urandom_range(1) == 1) payload[0] = cmd_id;
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_COMMAND_ID) cmd_id = value;
        else cmd_enable = value[0];
    endtask

    task automatic drain(input int limit);
        int n;
        n = 0;
        @(negedge i_clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (expected_results.size() != 0 && n < limit) begin
            @(negedge i_clk);
            n++;
        end
        while (expected_results.size() != 0) begin
            note_error($sformatf("missing result: event %0d",
                expected_results[0].event_res));
            void'(expected_results.pop_front());
        end
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int choice;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_COMMAND_ID, 8'h00);
                    write_reg(CFG_COMMAND_ENABLE, 8'h01);
                    send_idle = 0;
                    recv_stall = 0;
                end
                1: begin
                    write_reg(CFG_COMMAND_ID, 8'hFF);
                    write_reg(CFG_COMMAND_ENABLE, 8'h01);
                    send_idle = 57;
                    recv_stall = 0;
                end
                2: begin
                    write_reg(CFG_COMMAND_ID, 8'($urandom_range(255)));
                    write_reg(CFG_COMMAND_ENABLE, 8'h00);
                    send_idle = 0;
                    recv_stall = 57;
                end
                default: begin
                    write_reg(CFG_COMMAND_ID, FLAG_BYTE);
                    write_reg(CFG_COMMAND_ENABLE, 8'hFD);
                    send_idle = 23;
                    recv_stall = 23;
                end
            endcase
            @(negedge i_clk);
            queued = 0;
            if (p == 0) begin
                // idle noise, escape while idle
                send_raw(8'h00);
                send_raw(8'hFF);
                send_raw(ESC_BYTE);
                payload = '{8'h00, FLAG_BYTE, ESC_BYTE, 8'hFF, 8'h5A};
                send_frame(1'b0, 1'b1);
                // empty payload, good residue but too short
                payload.delete();
                send_frame(1'b0, 1'b1);
                payload = '{8'hA5};
                send_frame(1'b1, 1'b1);
                // frame opened by an escape and closed at once
                send_raw(ESC_BYTE);
                send_raw(FLAG_BYTE);
            end
            // long frame around the buffer limit
            fill_payload(124 + p);
            send_frame(1'b0, 1'b1);
            while (queued < 340) begin
                choice = $urandom_range(99);
                if (choice < 65) begin
                    fill_payload(($urandom_range(39) == 0) ? $urandom_range(128, 122)
                                                           : $urandom_range(16));
                    send_frame($urandom_range(9) == 0, 1'b1);
                end else if (choice < 75) begin
                    fill_payload($urandom_range(10));
                    send_frame(1'b0, 1'b0);
                end else if (choice < 85) begin
                    repeat ($urandom_range(6, 1)) begin
                        case ($urandom_range(3))
                            0: send_raw(FLAG_BYTE);
                            1: send_raw(ESC_BYTE);
                            default: send_raw(8'($urandom_range(255)));
                        endcase
                    end
                end else begin
                    fill_payload($urandom_range(2));
                    send_frame($urandom_range(3) == 0, 1'b1);
                end
            end
            drain(1000);
        end
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
